[hdl/i2cm_pkg.sv]
package i2cm_pkg;

   // Bus timing phases of the bit engine
   localparam logic [3:0] PH_IDLE  = 4'd0;
   localparam logic [3:0] PH_ST_A  = 4'd1;
   localparam logic [3:0] PH_ST_B  = 4'd2;
   localparam logic [3:0] PH_ST_C  = 4'd3;
   localparam logic [3:0] PH_SP_A  = 4'd4;
   localparam logic [3:0] PH_SP_B  = 4'd5;
   localparam logic [3:0] PH_SP_C  = 4'd6;
   localparam logic [3:0] PH_WR_LO = 4'd7;
   localparam logic [3:0] PH_WR_HI = 4'd8;
   localparam logic [3:0] PH_AK_LO = 4'd9;
   localparam logic [3:0] PH_AK_HI = 4'd10;
   localparam logic [3:0] PH_RD_LO = 4'd11;
   localparam logic [3:0] PH_RD_HI = 4'd12;
   localparam logic [3:0] PH_AO_LO = 4'd13;
   localparam logic [3:0] PH_AO_HI = 4'd14;

   // Command opcodes
   localparam logic [1:0] OP_START = 2'd0;
   localparam logic [1:0] OP_STOP  = 2'd1;
   localparam logic [1:0] OP_WRITE = 2'd2;
   localparam logic [1:0] OP_READ  = 2'd3;

   // Configuration register indexes
   localparam logic CSR_PHASE_TICKS = 1'b0;
   localparam logic CSR_ACK_TIMEOUT = 1'b1;

   localparam logic [15:0] PHASE_TICKS_RST = 16'd4;
   localparam logic [15:0] ACK_TIMEOUT_RST = 16'd205;
   localparam logic [3:0]  BITS_PER_BYTE   = 4'd8;

   typedef struct packed {
      logic [15:0] phase_ticks;
      logic [15:0] ack_timeout;
   } cfg_type;

   // Decoded tick: at most one command flag is set
   typedef struct packed {
      logic       is_start;
      logic       is_stop;
      logic       is_write;
      logic       is_read;
      logic [7:0] tx_byte;
      logic       send_ack;
      logic       sda_sample;
   } req_type;

   typedef struct packed {
      logic       scl_level;
      logic       sda_level;
      logic       sda_drive;
      logic       busy_res;
      logic       cmd_done;
      logic [7:0] rx_byte;
      logic       ack_error;
   } rsp_type;

endpackage

[hdl/i2cm_fifo.sv]
module i2cm_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [WIDTH-1:0] wr_data,
   output logic             is_full,
   input  logic             rd_en,
   output logic [WIDTH-1:0] rd_data,
   output logic             is_empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_wr, do_rd;

   assign is_full  = (count_ff == CNT_W'(DEPTH));
   assign is_empty = (count_ff == '0);
   assign do_wr    = wr_en && !is_full;
   assign do_rd    = rd_en && !is_empty;
   assign rd_data  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

[hdl/i2cm_front.sv]
module i2cm_front import i2cm_pkg::*; #(
   parameter int DEPTH = 2
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   output logic       full,
   input  logic       cmd_valid,
   input  logic [1:0] opcode,
   input  logic [7:0] tx_byte,
   input  logic       send_ack,
   input  logic       sda_sample,
   output req_type    item,
   output logic       item_valid,
   input  logic       item_pop
);

   req_type dec;
   logic    q_empty;

   // Classify the tick into one command flag
   always_comb begin
      dec            = '0;
      dec.tx_byte    = tx_byte;
      dec.send_ack   = send_ack;
      dec.sda_sample = sda_sample;
      if (cmd_valid) begin
         case (opcode)
            OP_START: dec.is_start = 1'b1;
            OP_STOP:  dec.is_stop  = 1'b1;
            OP_WRITE: dec.is_write = 1'b1;
            OP_READ:  dec.is_read  = 1'b1;
            default:  dec.is_start = 1'b0;
         endcase
      end
   end

   i2cm_fifo #(
      .WIDTH ($bits(req_type)),
      .DEPTH (DEPTH)
   ) u_req_q (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (push),
      .wr_data  (dec),
      .is_full  (full),
      .rd_en    (item_pop),
      .rd_data  (item),
      .is_empty (q_empty)
   );

   assign item_valid = !q_empty;

endmodule

[hdl/i2cm_engine.sv]
module i2cm_engine import i2cm_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  req_type item,
   input  logic    item_valid,
   output logic    item_pop,
   input  logic    rsp_full,
   output logic    rsp_push,
   output rsp_type rsp_data
);

   logic [3:0]  phase_ff, phase_in;
   logic [3:0]  bit_count_ff, bit_count_in;
   logic [7:0]  shift_ff, shift_in;
   logic [15:0] tick_ff, tick_in;
   logic [15:0] wait_ff, wait_in;
   logic        scl_ff, scl_in;
   logic        sda_ff, sda_in;
   logic        drive_ff, drive_in;
   logic        ack_flag_ff, ack_flag_in;
   logic [7:0]  rx_hold_ff, rx_hold_in;
   logic        ack_choice_ff, ack_choice_in;
   logic        finished;
   logic        fire;
   logic [15:0] pt;
   logic [15:0] tick_inc;
   logic [3:0]  bc_inc;
   logic [7:0]  rd_shift;

   assign fire     = item_valid && !rsp_full;
   assign item_pop = fire;
   assign rsp_push = fire;
   assign pt       = (cfg.phase_ticks == '0) ? 16'd1 : cfg.phase_ticks;
   assign tick_inc = tick_ff + 16'd1;
   assign bc_inc   = bit_count_ff + 4'd1;
   assign rd_shift = {shift_ff[6:0], item.sda_sample};

   always_comb begin
      phase_in      = phase_ff;
      bit_count_in  = bit_count_ff;
      shift_in      = shift_ff;
      tick_in       = tick_ff;
      wait_in       = wait_ff;
      scl_in        = scl_ff;
      sda_in        = sda_ff;
      drive_in      = drive_ff;
      ack_flag_in   = ack_flag_ff;
      rx_hold_in    = rx_hold_ff;
      ack_choice_in = ack_choice_ff;
      finished      = 1'b0;
      if (phase_ff == PH_IDLE) begin
         if (item.is_start || item.is_stop || item.is_write || item.is_read) begin
            ack_flag_in  = 1'b0;
            wait_in      = '0;
            bit_count_in = '0;
            tick_in      = '0;
            drive_in     = 1'b1;
         end
         if (item.is_start) begin
            phase_in = PH_ST_A;
            sda_in   = 1'b1;
         end else if (item.is_stop) begin
            phase_in = PH_SP_A;
            scl_in   = 1'b0;
         end else if (item.is_write) begin
            phase_in = PH_WR_LO;
            shift_in = item.tx_byte;
            scl_in   = 1'b0;
            sda_in   = item.tx_byte[7];
         end else if (item.is_read) begin
            phase_in      = PH_RD_LO;
            shift_in      = '0;
            ack_choice_in = item.send_ack;
            scl_in        = 1'b0;
            sda_in        = 1'b1;
            drive_in      = 1'b0;
         end
      end else if (phase_ff == PH_AK_HI) begin
         // Poll SDA every tick while SCL is high
         tick_in = 16'd1;
         if (!item.sda_sample) begin
            scl_in   = 1'b0;
            phase_in = PH_IDLE;
            tick_in  = '0;
            finished = 1'b1;
         end else if (wait_ff >= cfg.ack_timeout) begin
            ack_flag_in = 1'b1;
            phase_in    = PH_SP_A;
            tick_in     = '0;
            scl_in      = 1'b0;
            sda_in      = 1'b1;
            drive_in    = 1'b1;
         end else begin
            wait_in = wait_ff + 16'd1;
         end
      end else begin
         tick_in = tick_inc;
         if (tick_inc >= pt) begin
            tick_in = '0;
            case (phase_ff)
               PH_ST_A: begin
                  phase_in = PH_ST_B;
                  scl_in   = 1'b1;
                  sda_in   = 1'b1;
                  drive_in = 1'b1;
               end
               PH_ST_B: begin
                  phase_in = PH_ST_C;
                  scl_in   = 1'b1;
                  sda_in   = 1'b0;
                  drive_in = 1'b1;
               end
               PH_ST_C, PH_AO_HI: begin
                  scl_in   = 1'b0;
                  phase_in = PH_IDLE;
                  finished = 1'b1;
               end
               PH_SP_A: begin
                  phase_in = PH_SP_B;
                  scl_in   = 1'b0;
                  sda_in   = 1'b0;
                  drive_in = 1'b1;
               end
               PH_SP_B: begin
                  phase_in = PH_SP_C;
                  scl_in   = 1'b1;
                  sda_in   = 1'b0;
                  drive_in = 1'b1;
               end
               PH_SP_C: begin
                  sda_in   = 1'b1;
                  phase_in = PH_IDLE;
                  finished = 1'b1;
               end
               PH_WR_LO, PH_AO_LO: begin
                  phase_in = (phase_ff == PH_WR_LO) ? PH_WR_HI : PH_AO_HI;
                  scl_in   = 1'b1;
                  drive_in = 1'b1;
               end
               PH_WR_HI: begin
                  bit_count_in = bc_inc;
                  scl_in       = 1'b0;
                  if (bc_inc >= BITS_PER_BYTE) begin
                     phase_in = PH_AK_LO;
                     sda_in   = 1'b1;
                     drive_in = 1'b0;
                  end else begin
                     shift_in = {shift_ff[6:0], 1'b0};
                     phase_in = PH_WR_LO;
                     sda_in   = shift_ff[6];
                     drive_in = 1'b1;
                  end
               end
               PH_AK_LO: begin
                  phase_in = PH_AK_HI;
                  scl_in   = 1'b1;
                  sda_in   = 1'b1;
                  drive_in = 1'b0;
               end
               PH_RD_LO: begin
                  phase_in = PH_RD_HI;
                  scl_in   = 1'b1;
                  sda_in   = 1'b1;
                  drive_in = 1'b0;
               end
               PH_RD_HI: begin
                  shift_in     = rd_shift;
                  bit_count_in = bc_inc;
                  scl_in       = 1'b0;
                  if (bc_inc >= BITS_PER_BYTE) begin
                     rx_hold_in = rd_shift;
                     phase_in   = PH_AO_LO;
                     sda_in     = !ack_choice_ff;
                     drive_in   = 1'b1;
                  end else begin
                     phase_in = PH_RD_LO;
                     sda_in   = 1'b1;
                     drive_in = 1'b0;
                  end
               end
               default: begin
                  phase_in = PH_IDLE;
               end
            endcase
         end
      end
   end

   always_comb begin
      rsp_data.scl_level = scl_in;
      rsp_data.sda_level = sda_in;
      rsp_data.sda_drive = drive_in;
      rsp_data.busy_res  = (phase_in != PH_IDLE);
      rsp_data.cmd_done  = finished;
      rsp_data.rx_byte   = rx_hold_in;
      rsp_data.ack_error = ack_flag_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         bit_count_ff  <= '0;
         shift_ff      <= '0;
         tick_ff       <= '0;
         wait_ff       <= '0;
         scl_ff        <= 1'b1;
         sda_ff        <= 1'b1;
         drive_ff      <= 1'b1;
         ack_flag_ff   <= 1'b0;
         rx_hold_ff    <= '0;
         ack_choice_ff <= 1'b0;
      end else if (fire) begin
         phase_ff      <= phase_in;
         bit_count_ff  <= bit_count_in;
         shift_ff      <= shift_in;
         tick_ff       <= tick_in;
         wait_ff       <= wait_in;
         scl_ff        <= scl_in;
         sda_ff        <= sda_in;
         drive_ff      <= drive_in;
         ack_flag_ff   <= ack_flag_in;
         rx_hold_ff    <= rx_hold_in;
         ack_choice_ff <= ack_choice_in;
      end
   end

endmodule

[hdl/i2c_master_bit_engine.sv]
// I2C master bit engine. Each request is one timing tick: the sampled SDA
// level plus an optional command (start, stop, write byte, read byte).
// Every request yields exactly one response with the SCL/SDA pin levels,
// SDA drive enable, busy, command done, last received byte and ack error.
// Request channel: push/full, accepted when push is high and full is low.
// Response channel: empty/pop, the oldest response is on the rsp_ ports
// while empty is low and leaves when pop is high.
// Config channel: csr_valid/csr_ready (always ready), csr_index selects
// phase_ticks (0) or ack_timeout (1); write only while the engine is idle.
// Throughput: one request per cycle while the response queue has room.
// A request is registered in the request queue; the bit engine turns it
// into a response in the cycle it leaves, registered in the response queue.
// When the receiver stalls, the response queue fills, the engine holds,
// and the request queue raises full once its REQ_DEPTH entries are taken.
// Reset (synchronous, active high) empties both queues, returns the engine
// to idle with SCL high and SDA driven high, and restores phase_ticks to 4
// and ack_timeout to 205.
module i2c_master_bit_engine import i2cm_pkg::*; #(
   parameter int REQ_DEPTH = 2,
   parameter int RSP_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        push,
   output logic        full,
   input  logic        req_cmd_valid,
   input  logic [1:0]  req_opcode,
   input  logic [7:0]  req_tx_byte,
   input  logic        req_send_ack,
   input  logic        req_sda_sample,
   // response channel
   output logic        empty,
   input  logic        pop,
   output logic        rsp_scl_level,
   output logic        rsp_sda_level,
   output logic        rsp_sda_drive,
   output logic        rsp_busy_res,
   output logic        rsp_cmd_done,
   output logic [7:0]  rsp_rx_byte,
   output logic        rsp_ack_error,
   // configuration channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);

   cfg_type cfg_ff;
   req_type eng_item;
   logic    eng_item_valid;
   logic    eng_pop;
   logic    rsp_q_full;
   logic    eng_push;
   rsp_type eng_rsp;
   rsp_type rsp_head;

   // Config registers: always ready, written whenever csr_valid is high
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.phase_ticks <= PHASE_TICKS_RST;
         cfg_ff.ack_timeout <= ACK_TIMEOUT_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_PHASE_TICKS: cfg_ff.phase_ticks <= csr_wdata;
            CSR_ACK_TIMEOUT: cfg_ff.ack_timeout <= csr_wdata;
            default:         cfg_ff <= cfg_ff;
         endcase
      end
   end

   // Front: decode the command and hold the tick in the request queue
   i2cm_front #(
      .DEPTH (REQ_DEPTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (full),
      .cmd_valid  (req_cmd_valid),
      .opcode     (req_opcode),
      .tx_byte    (req_tx_byte),
      .send_ack   (req_send_ack),
      .sda_sample (req_sda_sample),
      .item       (eng_item),
      .item_valid (eng_item_valid),
      .item_pop   (eng_pop)
   );

   // Back: advance the bus phase machine by one tick per request
   i2cm_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .item       (eng_item),
      .item_valid (eng_item_valid),
      .item_pop   (eng_pop),
      .rsp_full   (rsp_q_full),
      .rsp_push   (eng_push),
      .rsp_data   (eng_rsp)
   );

   // Response queue decouples the engine from the consumer
   i2cm_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_q (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (eng_push),
      .wr_data  (eng_rsp),
      .is_full  (rsp_q_full),
      .rd_en    (pop),
      .rd_data  (rsp_head),
      .is_empty (empty)
   );

   assign rsp_scl_level = rsp_head.scl_level;
   assign rsp_sda_level = rsp_head.sda_level;
   assign rsp_sda_drive = rsp_head.sda_drive;
   assign rsp_busy_res  = rsp_head.busy_res;
   assign rsp_cmd_done  = rsp_head.cmd_done;
   assign rsp_rx_byte   = rsp_head.rx_byte;
   assign rsp_ack_error = rsp_head.ack_error;

`ifndef ASSERT_OFF
   // The engine never produces a response the queue cannot take
   a_no_rsp_overflow: assert property (@(posedge clock) disable iff (reset)
      eng_push |-> !rsp_q_full)
      else $error("response pushed into a full queue");

   // A completed command is no longer busy
   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_cmd_done) |-> !rsp_busy_res)
      else $error("cmd_done with busy set");

   // Released SDA always reads as high level
   a_release_high: assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_sda_drive) |-> rsp_sda_level)
      else $error("SDA released but level low");

   // A request is only consumed by the engine when the queue had one
   a_pop_needs_item: assert property (@(posedge clock) disable iff (reset)
      eng_pop |-> eng_item_valid)
      else $error("engine consumed from an empty request queue");
`endif

endmodule

[test/tb.sv]
`timescale 1ns / 100ps

module tb;
   import i2cm_pkg::*;

   // Cycle ceiling. The run holds a bit over a thousand ticks; with idle
   // bursts, the long receiver stall and the drains between sections it
   // still stays far below this.
   localparam int LIMIT    = 100_000;
   localparam int HOLD_LEN = 300;

   // One bus tick as it goes onto the request ports
   typedef struct {
      logic       cmd_valid;
      logic [1:0] opcode;
      logic [7:0] tx_byte;
      logic       send_ack;
      logic       sda_sample;
   } tick_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        full;
   logic        req_cmd_valid = 1'b0;
   logic [1:0]  req_opcode = OP_START;
   logic [7:0]  req_tx_byte = 8'h00;
   logic        req_send_ack = 1'b0;
   logic        req_sda_sample = 1'b1;
   logic        empty;
   logic        pop = 1'b0;
   logic        rsp_scl_level;
   logic        rsp_sda_level;
   logic        rsp_sda_drive;
   logic        rsp_busy_res;
   logic        rsp_cmd_done;
   logic [7:0]  rsp_rx_byte;
   logic        rsp_ack_error;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = CSR_PHASE_TICKS;
   logic [15:0] csr_wdata = 16'h0000;

   tick_type pending_ticks[$];
   rsp_type  expected_rsp[$];
   int       ticks_queued = 0;
   int       rsp_seen = 0;
   int       mismatches = 0;
   int       cycle_cnt = 0;
   int       send_gap = 0;
   int       take_gap = 0;
   bit       calm = 1'b0;
   bit       hold_go = 1'b0;
   bit       hold_rsp = 1'b0;

   // Bus engine shadow: configuration and state
   logic [15:0] cfg_phase_len;
   logic [15:0] cfg_ack_limit;
   logic [3:0]  bm_phase;
   logic [3:0]  bm_bits;
   logic [7:0]  bm_shift;
   logic [15:0] bm_ticks;
   logic [15:0] bm_polls;
   logic        bm_scl;
   logic        bm_sda;
   logic        bm_drive;
   logic        bm_ack_err;
   logic        bm_ack_sel;
   logic        bm_done;
   logic [7:0]  bm_rx;

   i2c_master_bit_engine dut (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .req_cmd_valid  (req_cmd_valid),
      .req_opcode     (req_opcode),
      .req_tx_byte    (req_tx_byte),
      .req_send_ack   (req_send_ack),
      .req_sda_sample (req_sda_sample),
      .empty          (empty),
      .pop            (pop),
      .rsp_scl_level  (rsp_scl_level),
      .rsp_sda_level  (rsp_sda_level),
      .rsp_sda_drive  (rsp_sda_drive),
      .rsp_busy_res   (rsp_busy_res),
      .rsp_cmd_done   (rsp_cmd_done),
      .rsp_rx_byte    (rsp_rx_byte),
      .rsp_ack_error  (rsp_ack_error),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Random values cut to field width
   function automatic logic rand_bit();
      return 1'($urandom);
   endfunction

   function automatic logic [1:0] rand_op();
      return 2'($urandom);
   endfunction

   function automatic logic [7:0] rand_byte();
      return 8'($urandom);
   endfunction

   // ---------------------------------------------------------------------
   // Bus engine prediction
   // ---------------------------------------------------------------------

   // Move to a new timing phase; a released SDA reads as high
   task automatic bus_enter(input logic [3:0] ph, input logic scl, input logic sda,
                            input logic drv);
      bm_phase = ph;
      bm_ticks = 16'd0;
      bm_scl   = scl;
      bm_drive = drv;
      bm_sda   = drv ? sda : 1'b1;
   endtask

   task automatic bus_finish();
      bm_phase = PH_IDLE;
      bm_ticks = 16'd0;
      bm_done  = 1'b1;
   endtask

   // Advance the shadow engine by one tick and queue the response it gives
   task automatic predict_bus_tick(input tick_type t);
      logic [15:0] span;
      rsp_type     r;
      span    = (cfg_phase_len == 16'd0) ? 16'd1 : cfg_phase_len;
      bm_done = 1'b0;
      if (bm_phase == PH_IDLE) begin
         if (t.cmd_valid) begin
            // any accepted command clears the old ack error
            bm_ack_err = 1'b0;
            bm_polls   = 16'd0;
            bm_bits    = 4'd0;
            case (t.opcode)
               OP_START: bus_enter(PH_ST_A, bm_scl, 1'b1, 1'b1);
               OP_STOP:  bus_enter(PH_SP_A, 1'b0, bm_sda, 1'b1);
               OP_WRITE: begin
                  bm_shift = t.tx_byte;
                  bus_enter(PH_WR_LO, 1'b0, t.tx_byte[7], 1'b1);
               end
               default: begin
                  bm_shift   = 8'h00;
                  bm_ack_sel = t.send_ack;
                  bus_enter(PH_RD_LO, 1'b0, 1'b1, 1'b0);
               end
            endcase
         end
      end else if (bm_phase == PH_AK_HI) begin
         // SCL high, poll SDA every tick for the slave ACK
         bm_ticks = 16'd1;
         if (!t.sda_sample) begin
            bm_scl = 1'b0;
            bus_finish();
         end else if (bm_polls >= cfg_ack_limit) begin
            bm_ack_err = 1'b1;
            bus_enter(PH_SP_A, 1'b0, 1'b1, 1'b1);
         end else begin
            bm_polls = bm_polls + 16'd1;
         end
      end else begin
         bm_ticks = bm_ticks + 16'd1;
         if (bm_ticks >= span) begin
            case (bm_phase)
               PH_ST_A:  bus_enter(PH_ST_B, 1'b1, 1'b1, 1'b1);
               PH_ST_B:  bus_enter(PH_ST_C, 1'b1, 1'b0, 1'b1);
               PH_ST_C: begin
                  bm_scl = 1'b0;
                  bus_finish();
               end
               PH_SP_A:  bus_enter(PH_SP_B, 1'b0, 1'b0, 1'b1);
               PH_SP_B:  bus_enter(PH_SP_C, 1'b1, 1'b0, 1'b1);
               PH_SP_C: begin
                  bm_sda = 1'b1;
                  bus_finish();
               end
               PH_WR_LO: bus_enter(PH_WR_HI, 1'b1, bm_sda, 1'b1);
               PH_WR_HI: begin
                  bm_bits = bm_bits + 4'd1;
                  if (bm_bits >= BITS_PER_BYTE) begin
                     bus_enter(PH_AK_LO, 1'b0, 1'b1, 1'b0);
                  end else begin
                     bm_shift = bm_shift << 1;
                     bus_enter(PH_WR_LO, 1'b0, bm_shift[7], 1'b1);
                  end
               end
               PH_AK_LO: bus_enter(PH_AK_HI, 1'b1, 1'b1, 1'b0);
               PH_RD_LO: bus_enter(PH_RD_HI, 1'b1, 1'b1, 1'b0);
               PH_RD_HI: begin
                  // sample on the last tick of SCL high
                  bm_shift = {bm_shift[6:0], t.sda_sample};
                  bm_bits  = bm_bits + 4'd1;
                  if (bm_bits >= BITS_PER_BYTE) begin
                     bm_rx = bm_shift;
                     bus_enter(PH_AO_LO, 1'b0, !bm_ack_sel, 1'b1);
                  end else begin
                     bus_enter(PH_RD_LO, 1'b0, 1'b1, 1'b0);
                  end
               end
               PH_AO_LO: bus_enter(PH_AO_HI, 1'b1, bm_sda, 1'b1);
               PH_AO_HI: begin
                  bm_scl = 1'b0;
                  bus_finish();
               end
               default: begin
                  bm_phase = PH_IDLE;
                  bm_ticks = 16'd0;
               end
            endcase
         end
      end
      r.scl_level = bm_scl;
      r.sda_level = bm_sda;
      r.sda_drive = bm_drive;
      r.busy_res  = (bm_phase != PH_IDLE);
      r.cmd_done  = bm_done;
      r.rx_byte   = bm_rx;
      r.ack_error = bm_ack_err;
      expected_rsp.push_back(r);
   endtask

   // ---------------------------------------------------------------------
   // Stimulus building
   // ---------------------------------------------------------------------

   task automatic add_tick(input logic vld, input logic [1:0] op, input logic [7:0] tx,
                           input logic sack, input logic sda);
      tick_type t;
      t.cmd_valid  = vld;
      t.opcode     = op;
      t.tx_byte    = tx;
      t.send_ack   = sack;
      t.sda_sample = sda;
      pending_ticks.push_back(t);
      ticks_queued++;
   endtask

   // Ticks while a command runs; with stray set, now and then slip in a
   // command that the busy engine must drop
   task automatic add_busy_ticks(input int n, input bit stray);
      for (int i = 0; i < n; i++) begin
         add_tick(stray && $urandom_range(0, 15) == 0, rand_op(), rand_byte(), rand_bit(),
                  rand_bit());
      end
   endtask

   // One well-formed command and the ticks it needs to complete.
   // ack_after: high polls before the slave pulls SDA low; past the limit
   // the slave never answers and the engine aborts with a stop.
   task automatic add_command(input logic [1:0] op, input logic [7:0] tx,
                              input logic sack, input int ack_after, input bit stray);
      int span;
      int lim;
      span = (cfg_phase_len == 16'd0) ? 1 : int'(cfg_phase_len);
      lim  = int'(cfg_ack_limit);
      add_tick(1'b1, op, tx, sack, rand_bit());
      case (op)
         OP_START, OP_STOP: add_busy_ticks(3 * span, stray);
         OP_READ:           add_busy_ticks(18 * span, stray);
         default: begin
            add_busy_ticks(17 * span, stray);
            if (ack_after > lim) begin
               repeat (lim + 1) add_tick(1'b0, rand_op(), rand_byte(), rand_bit(), 1'b1);
               add_busy_ticks(3 * span, stray);
            end else begin
               repeat (ack_after) add_tick(1'b0, rand_op(), rand_byte(), rand_bit(), 1'b1);
               add_tick(1'b0, rand_op(), rand_byte(), rand_bit(), 1'b0);
            end
         end
      endcase
   endtask

   // Mostly well-formed command streams, some raw noise followed by a
   // quiet tail with SDA low that brings the engine back to idle
   task automatic add_random_traffic(input int n_ticks);
      int stop_at;
      int span;
      int lim;
      int roll;
      int ack_after;
      stop_at = ticks_queued + n_ticks;
      span    = (cfg_phase_len == 16'd0) ? 1 : int'(cfg_phase_len);
      lim     = int'(cfg_ack_limit);
      while (ticks_queued < stop_at) begin
         roll = $urandom_range(0, 19);
         if (roll < 2) begin
            repeat ($urandom_range(4, 16))
               add_tick(rand_bit(), rand_op(), rand_byte(), rand_bit(), rand_bit());
            repeat (20 * span + 4) add_tick(1'b0, rand_op(), rand_byte(), rand_bit(), 1'b0);
         end else if (roll < 6) begin
            add_command(OP_START, rand_byte(), rand_bit(), 0, 1'b1);
         end else if (roll < 13) begin
            case ($urandom_range(0, 4))
               0:       ack_after = lim + 1;
               1, 2:    ack_after = 0;
               default: ack_after = $urandom_range(0, lim);
            endcase
            add_command(OP_WRITE, rand_byte(), rand_bit(), ack_after, 1'b1);
         end else if (roll < 18) begin
            add_command(OP_READ, rand_byte(), rand_bit(), 0, 1'b1);
         end else begin
            add_command(OP_STOP, rand_byte(), rand_bit(), 0, 1'b1);
         end
         // idle ticks between commands: nothing happens
         repeat ($urandom_range(0, 2))
            add_tick(1'b0, rand_op(), rand_byte(), rand_bit(), rand_bit());
      end
   endtask

   task automatic write_csr(input logic idx, input logic [15:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_PHASE_TICKS) cfg_phase_len = val;
      else cfg_ack_limit = val;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_timing(input logic [15:0] phase_len, input logic [15:0] ack_limit);
      write_csr(CSR_PHASE_TICKS, phase_len);
      write_csr(CSR_ACK_TIMEOUT, ack_limit);
   endtask

   // Hold until every request went in and every response came back
   task automatic wait_drained();
      while (pending_ticks.size() != 0 || expected_rsp.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic note_mismatch(input string msg);
      $display("[%0t] %s", $realtime, msg);
      mismatches++;
   endtask

   task automatic check_field(input string name, input logic [7:0] got,
                              input logic [7:0] want);
      if (got !== want)
         note_mismatch($sformatf("response %0d: %s got 'h%0h want 'h%0h", rsp_seen, name,
                                 got, want));
   endtask

   // ---------------------------------------------------------------------
   // Request driver: offer the head of the pending queue, idle in bursts
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         push <= 1'b0;
      end else if (send_gap > 0) begin
         push     <= 1'b0;
         send_gap <= send_gap - 1;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
         push     <= 1'b0;
         send_gap <= $urandom_range(0, 8);
      end else if (pending_ticks.size() != 0) begin
         push           <= 1'b1;
         req_cmd_valid  <= pending_ticks[0].cmd_valid;
         req_opcode     <= pending_ticks[0].opcode;
         req_tx_byte    <= pending_ticks[0].tx_byte;
         req_send_ack   <= pending_ticks[0].send_ack;
         req_sda_sample <= pending_ticks[0].sda_sample;
      end else begin
         push <= 1'b0;
      end
   end

   // Response side: pop in bursts, and drop pop entirely during a hold-off
   always @(negedge clock) begin
      if (reset || hold_rsp) begin
         pop <= 1'b0;
      end else if (take_gap > 0) begin
         pop      <= 1'b0;
         take_gap <= take_gap - 1;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
         pop      <= 1'b0;
         take_gap <= $urandom_range(0, 8);
      end else begin
         pop <= 1'b1;
      end
   end

   // Long receiver stall, counted here, so both queues fill and full rises
   initial begin
      wait (hold_go);
      @(posedge clock);
      hold_rsp = 1'b1;
      repeat (HOLD_LEN) @(posedge clock);
      hold_rsp = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Monitor: check popped responses, then predict for accepted requests
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      rsp_type want;
      if (!reset) begin
         if (pop && !empty) begin
            if (expected_rsp.size() == 0) begin
               note_mismatch($sformatf("response %0d arrived with nothing expected",
                                       rsp_seen));
            end else begin
               want = expected_rsp.pop_front();
               check_field("scl_level", rsp_scl_level, want.scl_level);
               check_field("sda_level", rsp_sda_level, want.sda_level);
               check_field("sda_drive", rsp_sda_drive, want.sda_drive);
               check_field("busy_res", rsp_busy_res, want.busy_res);
               check_field("cmd_done", rsp_cmd_done, want.cmd_done);
               check_field("rx_byte", rsp_rx_byte, want.rx_byte);
               check_field("ack_error", rsp_ack_error, want.ack_error);
            end
            rsp_seen++;
         end
         if (push && !full) begin
            predict_bus_tick(pending_ticks[0]);
            void'(pending_ticks.pop_front());
         end
      end
   end

   // Cycle counter: end a run that hangs
   initial begin
      while (cycle_cnt < LIMIT) begin
         @(posedge clock);
         cycle_cnt++;
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------
   initial begin
      // shadow engine comes out of reset idle with SCL high and SDA driven high
      cfg_phase_len = PHASE_TICKS_RST;
      cfg_ack_limit = ACK_TIMEOUT_RST;
      bm_phase      = PH_IDLE;
      bm_bits       = 4'd0;
      bm_shift      = 8'h00;
      bm_ticks      = 16'd0;
      bm_polls      = 16'd0;
      bm_scl        = 1'b1;
      bm_sda        = 1'b1;
      bm_drive      = 1'b1;
      bm_ack_err    = 1'b0;
      bm_ack_sel    = 1'b0;
      bm_done       = 1'b0;
      bm_rx         = 8'h00;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset timing: idle ticks, a full transfer, a stray command mid-byte
      add_tick(1'b0, OP_WRITE, 8'hFF, 1'b1, 1'b0);
      add_tick(1'b0, OP_READ, 8'h00, 1'b0, 1'b1);
      add_command(OP_START, 8'h00, 1'b0, 0, 1'b0);
      add_command(OP_WRITE, 8'hA5, 1'b0, 3, 1'b1);
      add_command(OP_READ, 8'h00, 1'b1, 0, 1'b0);
      add_command(OP_WRITE, 8'h5A, 1'b1, 0, 1'b0);
      add_command(OP_READ, 8'hFF, 1'b0, 0, 1'b1);
      add_command(OP_STOP, 8'h00, 1'b0, 0, 1'b0);
      wait_drained();

      // Phase length zero acts as one tick; timeout zero aborts on the
      // first high poll
      set_timing(16'd0, 16'd0);
      add_tick(1'b1, OP_START, 8'h00, 1'b0, 1'b1);
      add_tick(1'b1, OP_STOP, 8'hFF, 1'b1, 1'b0);
      add_tick(1'b1, OP_WRITE, 8'h00, 1'b0, 1'b1);
      add_tick(1'b1, OP_READ, 8'hFF, 1'b1, 1'b0);
      add_command(OP_WRITE, 8'hFF, 1'b0, 1, 1'b0);
      add_command(OP_WRITE, 8'h00, 1'b0, 0, 1'b0);
      add_command(OP_READ, 8'h00, 1'b1, 0, 1'b0);
      add_command(OP_READ, 8'h00, 1'b0, 0, 1'b0);
      add_command(OP_START, 8'h00, 1'b0, 0, 1'b0);
      add_command(OP_STOP, 8'h00, 1'b0, 0, 1'b0);
      wait_drained();

      // Random traffic; stall the receiver for a while in the first round
      set_timing(16'd1, 16'd2);
      hold_go = 1'b1;
      add_random_traffic(200);
      wait_drained();
      repeat (3) begin
         set_timing(16'($urandom_range(1, 3)), 16'($urandom_range(0, 9)));
         add_random_traffic(80);
         wait_drained();
      end

      // Last stretch: no idling on either side, then the register extremes
      calm = 1'b1;
      set_timing(16'd2, 16'd4);
      add_random_traffic(80);
      wait_drained();
      set_timing(16'd1, 16'hFFFF);
      add_command(OP_WRITE, rand_byte(), 1'b0, 40, 1'b0);
      add_command(OP_WRITE, rand_byte(), 1'b0, 0, 1'b0);
      wait_drained();
      // the longest phase: the engine stays in its first start phase
      set_timing(16'hFFFF, ACK_TIMEOUT_RST);
      add_tick(1'b1, OP_START, 8'h00, 1'b0, 1'b1);
      add_busy_ticks(12, 1'b1);
      wait_drained();

      // let any stray response surface before the verdict
      repeat (8) @(negedge clock);
      if (mismatches == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
